// ----- rtl/splitmix64_ranged_random_macros.svh -----
// assertion helpers for the ranged splitmix64 generator
// each expects clk and arst_n in the scope where it is used
`ifndef SPLITMIX64_RANGED_RANDOM_MACROS_SVH
`define SPLITMIX64_RANGED_RANDOM_MACROS_SVH

// same-cycle implication
`define SMR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/smr_pkg.sv -----
`default_nettype none

package smr_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned HALF_W = DATA_W / 2;
	localparam int unsigned CNT_W  = $clog2(DATA_W + 1);
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [DATA_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [DATA_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [DATA_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
	localparam int unsigned MIX_SH_A = 30;
	localparam int unsigned MIX_SH_B = 27;
	localparam int unsigned MIX_SH_C = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED_WORD    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_SQUARED = 1'd1;

	localparam logic [DATA_W-1:0] SEED_WORD_RESET    = 64'd1;
	localparam logic              SEED_SQUARED_RESET = 1'b1;

	// which 32x32 partial product of the 64-bit low product
	typedef enum logic [1:0] {
		PP_LL = 2'd0,
		PP_HL = 2'd1,
		PP_LH = 2'd2
	} pp_sel_t;

	typedef struct packed {
		logic    load;
		logic    mix_a;
		logic    mix_b;
		logic    pp_en;
		pp_sel_t pp_sel;
		logic    acc_en;
		logic    acc_first;
		logic    seed_load;
		logic    div1_init;
		logic    div2_init;
		logic    div_step;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic reseed;
		logic div_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/smr_datapath.sv -----
`default_nettype none

module smr_datapath
	import smr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 reseed,
	input  wire logic                 wide,
	input  wire logic [DATA_W-1:0]    low_bound,
	input  wire logic [DATA_W-1:0]    high_bound,
	input  wire logic [DATA_W-1:0]    step,
	input  wire dp_cmd_t              cmd,
	output dp_status_t                status,
	output logic [DATA_W-1:0]         value,
	output logic [DATA_W-1:0]         state_now
);

	logic [DATA_W-1:0] seed_word_q;
	logic              seed_sq_q;
	logic [DATA_W-1:0] gen_state_q;

	logic              reseed_q;
	logic              wide_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] step_q;

	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] pp_q;
	logic              pp_hi_q;
	logic [DATA_W-1:0] acc_q;

	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] t1_q;

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] state_now_q;

	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [DATA_W-1:0] pp_now;
	logic [DATA_W-1:0] pp_shifted;
	logic [DATA_W-1:0] t_mix;
	logic [DATA_W-1:0] span64;
	logic [HALF_W-1:0] span32;
	logic [HALF_W-1:0] step32;
	logic [DATA_W-1:0] step_eff;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic [DATA_W-1:0] t1_now;
	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] res_wide;
	logic [HALF_W-1:0] res_narrow;
	logic [CNT_W-1:0]  iter_count;

	// configuration and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_word_q <= SEED_WORD_RESET;
			seed_sq_q   <= SEED_SQUARED_RESET;
			gen_state_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEED_WORD:    seed_word_q <= cfg_data;
					CFG_SEED_SQUARED: seed_sq_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load && !reseed) begin
				gen_state_q <= gen_state_q + GOLDEN_INC;
			end else if (cmd.seed_load) begin
				gen_state_q <= seed_sq_q ? acc_q : seed_word_q;
			end
		end
	end

	// partial product operand selection
	always_comb begin
		case (cmd.pp_sel)
			PP_LL: begin
				mul_a = x_q[HALF_W-1:0];
				mul_b = y_q[HALF_W-1:0];
			end
			PP_HL: begin
				mul_a = x_q[DATA_W-1:HALF_W];
				mul_b = y_q[HALF_W-1:0];
			end
			PP_LH: begin
				mul_a = x_q[HALF_W-1:0];
				mul_b = y_q[DATA_W-1:HALF_W];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// full 64-bit product of the two 32-bit operands
	assign pp_now     = DATA_W'(mul_a) * DATA_W'(mul_b);
	assign pp_shifted = pp_hi_q ? {pp_q[HALF_W-1:0], {HALF_W{1'b0}}} : pp_q;

	assign t_mix  = acc_q ^ (acc_q >> MIX_SH_C);
	assign span64 = hi_q - lo_q + {{(DATA_W-1){1'b0}}, 1'b1};
	assign span32 = hi_q[HALF_W-1:0] - lo_q[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, 1'b1};
	assign step32 = step_q[HALF_W-1:0];

	always_comb begin
		if (wide_q) begin
			step_eff = (step_q == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : step_q;
		end else begin
			step_eff = (step32 == '0) ? {{(DATA_W-1){1'b0}}, 1'b1}
			                          : {{HALF_W{1'b0}}, step32};
		end
	end

	assign iter_count = wide_q ? CNT_W'(DATA_W) : CNT_W'(HALF_W);

	// restoring remainder step; a zero divisor leaves the dividend itself
	assign rem_sh  = {rem_q, dvd_q[DATA_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign t1_now  = rem_q;

	assign diff       = t1_q - rem_q;
	assign res_wide   = lo_q + diff;
	assign res_narrow = lo_q[HALF_W-1:0] + diff[HALF_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reseed_q <= reseed;
			wide_q   <= wide;
			lo_q     <= low_bound;
			hi_q     <= high_bound;
			step_q   <= step;
			x_q      <= reseed ? seed_word_q : gen_state_q;
			y_q      <= seed_word_q;
		end else if (cmd.mix_a) begin
			x_q <= x_q ^ (x_q >> MIX_SH_A);
			y_q <= MIX_MUL_A;
		end else if (cmd.mix_b) begin
			x_q <= acc_q ^ (acc_q >> MIX_SH_B);
			y_q <= MIX_MUL_B;
		end

		if (cmd.pp_en) begin
			pp_q    <= pp_now;
			pp_hi_q <= (cmd.pp_sel != PP_LL);
		end
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_first ? pp_shifted : acc_q + pp_shifted;
		end

		if (cmd.div1_init) begin
			dvd_q <= wide_q ? t_mix : {t_mix[HALF_W-1:0], {HALF_W{1'b0}}};
			dvs_q <= wide_q ? span64 : {{HALF_W{1'b0}}, span32};
			rem_q <= '0;
			cnt_q <= iter_count;
		end else if (cmd.div2_init) begin
			t1_q  <= t1_now;
			dvd_q <= wide_q ? t1_now : {t1_now[HALF_W-1:0], {HALF_W{1'b0}}};
			dvs_q <= step_eff;
			rem_q <= '0;
			cnt_q <= iter_count;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= (rem_sh >= {1'b0, dvs_q}) ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
		end

		if (cmd.out_load) begin
			state_now_q <= gen_state_q;
			if (reseed_q) begin
				value_q <= '0;
			end else if (wide_q) begin
				value_q <= res_wide;
			end else begin
				value_q <= {{HALF_W{1'b0}}, res_narrow};
			end
		end
	end

	assign status.reseed   = reseed_q;
	assign status.div_last = (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1});

	assign value     = value_q;
	assign state_now = state_now_q;

endmodule

`default_nettype wire

// ----- rtl/smr_ctrl.sv -----
`default_nettype none

module smr_ctrl
	import smr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            in_stall,
	output logic            out_valid
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SQ    = 12'b0000_0000_0010,
		ST_SEED  = 12'b0000_0000_0100,
		ST_MIXA  = 12'b0000_0000_1000,
		ST_MULA  = 12'b0000_0001_0000,
		ST_MIXB  = 12'b0000_0010_0000,
		ST_MULB  = 12'b0000_0100_0000,
		ST_DIV1I = 12'b0000_1000_0000,
		ST_DIV1  = 12'b0001_0000_0000,
		ST_DIV2I = 12'b0010_0000_0000,
		ST_DIV2  = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic [1:0]  phase_q;
	logic [1:0]  phase_d;
	logic        out_valid_q;
	logic        accept;
	logic        out_free;
	pp_sel_t     sel_now;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (phase_q)
			2'd0:    sel_now = PP_LL;
			2'd1:    sel_now = PP_HL;
			default: sel_now = PP_LH;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.pp_sel = PP_LL;
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					phase_d  = 2'd0;
					state_d  = status.reseed ? ST_SQ : ST_MIXA;
				end
			end
			ST_SQ: begin
				cmd.pp_en     = (phase_q == 2'd0);
				cmd.acc_en    = (phase_q == 2'd1);
				cmd.acc_first = 1'b1;
				phase_d       = phase_q + 2'd1;
				if (phase_q == 2'd1) begin
					phase_d = 2'd0;
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed_load = 1'b1;
				state_d       = ST_DONE;
			end
			ST_MIXA: begin
				cmd.mix_a = 1'b1;
				state_d   = ST_MULA;
			end
			ST_MULA, ST_MULB: begin
				cmd.pp_en     = (phase_q != 2'd3);
				cmd.pp_sel    = sel_now;
				cmd.acc_en    = (phase_q != 2'd0);
				cmd.acc_first = (phase_q == 2'd1);
				phase_d       = phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					state_d = (state_q == ST_MULA) ? ST_MIXB : ST_DIV1I;
				end
			end
			ST_MIXB: begin
				cmd.mix_b = 1'b1;
				state_d   = ST_MULB;
			end
			ST_DIV1I: begin
				cmd.div1_init = 1'b1;
				state_d       = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DIV2I;
				end
			end
			ST_DIV2I: begin
				cmd.div2_init = 1'b1;
				state_d       = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				phase_d = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = !accept && (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/splitmix64_ranged_random.sv -----
// Ranged SplitMix64 generator. Each request either reseeds the generator
// (reseed high: state loaded from seed_word, squared from its low 32 bits when
// seed_squared is set; value returns 0) or draws one number: the state steps
// by the golden-ratio increment, the old state is mixed to 64 bits, truncated
// to 32 when wide is low, reduced modulo (high_bound - low_bound + 1), rounded
// down to a multiple of step and offset by low_bound, all wrapping at the
// working width. A span that wraps to zero keeps the draw whole; a zero step
// counts as one. Every request returns exactly one result with state_now, the
// state after the request. One request is in flight at a time. A draw runs
// two bit-serial remainder passes (one quotient bit a cycle, 64 or 32 each)
// and two mixing multiplies, each built from three 32x32 partial products on
// one shared multiplier. A new request is taken while the previous result
// still sits in the output register. Configuration writes must be made only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "splitmix64_ranged_random_macros.svh"

module splitmix64_ranged_random
	import smr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 reseed,
	input  wire logic                 wide,
	input  wire logic [DATA_W-1:0]    low_bound,
	input  wire logic [DATA_W-1:0]    high_bound,
	input  wire logic [DATA_W-1:0]    step,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [DATA_W-1:0]         value,
	output logic [DATA_W-1:0]         state_now
);

	// command and status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t status;
	dp_status_t ctrl_status;

	// the request type is needed as the request is taken, before it is registered
	assign ctrl_status.reseed   = (in_valid && !in_stall) ? reseed : status.reseed;
	assign ctrl_status.div_last = status.div_last;

	smr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (ctrl_status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// holds the seed registers, generator state, multiplier and remainder unit
	smr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.reseed     (reseed),
		.wide       (wide),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.step       (step),
		.cmd        (cmd),
		.status     (status),
		.value      (value),
		.state_now  (state_now)
	);

	// a taken request keeps the block busy on the following cycle
	`SMR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "idle right after a request")
	// a draw keeps the block busy into the first mixing multiply
	`SMR_ASSERT_NEXT(a_draw_long, in_valid && !in_stall && !reseed, ##2 in_stall, "draw ended early")
	// a fresh result appears only as the sequencer returns to idle
	`SMR_ASSERT_NOW(a_result_idle, $rose(out_valid), !in_stall, "result while still busy")

endmodule

`default_nettype wire

// ----- dv/splitmix64_ranged_random_tb.sv -----
`default_nettype none

module splitmix64_ranged_random_tb
	import smr_pkg::*;
();

	localparam int unsigned HALF_PERIOD     = 5;
	localparam int unsigned RESET_CYCLES    = 8;
	localparam int unsigned ITEMS_PER_PHASE = 262;
	// longest quiet stretch of a correct run: the longest sender gap, a wide
	// draw and a receiver stall, taken several times over
	localparam int unsigned IDLE_LIMIT      = 2000;
	localparam int unsigned DRAIN_CYCLES    = 300;
	localparam int unsigned MAX_PRINTED     = 40;

	// splitmix64 increment and mixing multipliers
	localparam logic [DATA_W-1:0] WEYL_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [DATA_W-1:0] MIX_K1    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [DATA_W-1:0] MIX_K2    = 64'h94D0_49BB_1331_11EB;

	typedef struct {
		logic              reseed;
		logic              wide;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] stp;
	} draw_req_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] state_now;
	} draw_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 reseed;
	logic                 wide;
	logic [DATA_W-1:0]    low_bound;
	logic [DATA_W-1:0]    high_bound;
	logic [DATA_W-1:0]    step;
	logic                 out_valid;
	logic                 out_stall;
	logic [DATA_W-1:0]    value;
	logic [DATA_W-1:0]    state_now;

	// requests waiting for the driver, and results predicted at acceptance
	draw_req_t    pending_requests[$];
	draw_result_t predicted_results[$];

	// predictor copy of the generator and its seed registers
	logic [DATA_W-1:0] gen_state = '0;
	logic [DATA_W-1:0] seed_cfg;
	logic              squared_cfg;

	int unsigned n_submitted = 0;
	int unsigned n_checked   = 0;
	int unsigned n_errors    = 0;
	int unsigned idle_cycles = 0;

	// driver and monitor bookkeeping
	draw_req_t    cur_req;
	int unsigned  burst_left = 0;
	int unsigned  gap_left   = 0;
	draw_result_t oldest;
	int unsigned  stall_mode = 0;
	int unsigned  stall_left = 0;

	splitmix64_ranged_random dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.reseed     (reseed),
		.wide       (wide),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.step       (step),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.state_now  (state_now)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// splitmix64 finaliser on the pre-advance state
	function automatic logic [DATA_W-1:0] mix64(input logic [DATA_W-1:0] z);
		z = (z ^ (z >> 30)) * MIX_K1;
		z = (z ^ (z >> 27)) * MIX_K2;
		return z ^ (z >> 31);
	endfunction

	// works out the result of one accepted request and queues it
	task automatic predict_draw(input draw_req_t r);
		logic [DATA_W-1:0] draw;
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] stp;
		logic [DATA_W-1:0] res;
		logic [HALF_W-1:0] t32;
		logic [HALF_W-1:0] span32;
		logic [HALF_W-1:0] stp32;
		draw_result_t      exp_res;
		res = '0;
		if (r.reseed) begin
			if (squared_cfg)
				gen_state = {32'd0, seed_cfg[31:0]} * {32'd0, seed_cfg[31:0]};
			else
				gen_state = seed_cfg;
		end else begin
			draw = mix64(gen_state);
			gen_state = gen_state + WEYL_STEP;
			if (r.wide) begin
				// a span that wraps to zero leaves the draw whole
				span = r.hi - r.lo + 64'd1;
				if (span != '0)
					draw = draw % span;
				stp = (r.stp == '0) ? 64'd1 : r.stp;
				res = r.lo + (draw - draw % stp);
			end else begin
				// narrow mode: only the low halves count, all wrapping at 32 bits
				t32 = draw[31:0];
				span32 = r.hi[31:0] - r.lo[31:0] + 32'd1;
				if (span32 != '0)
					t32 = t32 % span32;
				stp32 = (r.stp[31:0] == '0) ? 32'd1 : r.stp[31:0];
				res = {32'd0, r.lo[31:0] + (t32 - t32 % stp32)};
			end
		end
		exp_res.value = res;
		exp_res.state_now = gen_state;
		predicted_results.push_back(exp_res);
	endtask

	task automatic report_mismatch(input string msg);
		if (n_errors < MAX_PRINTED)
			$display("mismatch: %s", msg);
		n_errors++;
	endtask

	task automatic push_request(input logic rs, input logic wd, input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] stp);
		draw_req_t r;
		r.reseed = rs;
		r.wide = wd;
		r.lo = lo;
		r.hi = hi;
		r.stp = stp;
		pending_requests.push_back(r);
		n_submitted++;
	endtask

	// random request, mostly draws with ranges chosen to hit the awkward cases
	task automatic push_random_request();
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] stp;
		lo = rand64();
		case ($urandom_range(0, 5))
			0: hi = lo + 64'($urandom_range(0, 15));      // tiny span
			1: hi = lo + {32'd0, $urandom};              // span up to 2^32
			2: hi = lo + (rand64() >> $urandom_range(0, 63));
			3: hi = lo - 64'd1;                          // full width span
			default: hi = rand64();                      // anything, often inverted
		endcase
		case ($urandom_range(0, 5))
			0: stp = '0;
			1: stp = 64'd1;
			2: stp = 64'($urandom_range(2, 9));
			3: stp = rand64() >> $urandom_range(0, 63);
			4: stp = {$urandom, 32'd0} | 64'($urandom_range(0, 1));
			default: stp = rand64();
		endcase
		push_request($urandom_range(0, 99) < 5, 1'($urandom_range(0, 1)), lo, hi, stp);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_SEED_WORD)
			seed_cfg = data;
		else if (idx == CFG_SEED_SQUARED)
			squared_cfg = data[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (n_checked != n_submitted)
			@(posedge clk);
	endtask

	// one configuration phase: idle, new seed settings, a reseed, then random requests
	task automatic run_phase(input logic [DATA_W-1:0] seed, input logic sq,
			input logic [DATA_W-1:0] junk);
		wait_idle();
		write_reg(CFG_SEED_WORD, seed);
		write_reg(CFG_SEED_SQUARED, {junk[DATA_W-1:1], sq});
		push_request(1'b1, 1'($urandom_range(0, 1)), rand64(), rand64(), rand64());
		repeat (ITEMS_PER_PHASE - 1)
			push_random_request();
	endtask

	// driver: request bursts of random length with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			reseed <= 1'b0;
			wide <= 1'b0;
			low_bound <= '0;
			high_bound <= '0;
			step <= '0;
		end else begin
			// request taken at this edge: predict before anything moves
			if (in_valid && !in_stall)
				predict_draw(cur_req);
			// the payload may only change once the current request is gone
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					cur_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					reseed <= cur_req.reseed;
					wide <= cur_req.wide;
					low_bound <= cur_req.lo;
					high_bound <= cur_req.hi;
					step <= cur_req.stp;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 30);
						// gaps from none to longer than a wide draw
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 4);
							2: gap_left = $urandom_range(5, 40);
							default: gap_left = $urandom_range(41, 200);
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result against the oldest prediction, stalls in modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: value %h state %h",
						value, state_now));
				end else begin
					oldest = predicted_results.pop_front();
					if (value !== oldest.value)
						report_mismatch($sformatf("result %0d value %h, predicted %h",
							n_checked, value, oldest.value));
					if (state_now !== oldest.state_now)
						report_mismatch($sformatf("result %0d state_now %h, predicted %h",
							n_checked, state_now, oldest.state_now));
					n_checked++;
				end
			end
			// stall pattern: free flow, light random, or heavy back-pressure
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(16, 400);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog on cycles with no request or result taken
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("splitmix64_ranged_random test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// reset values of the predictor's seed registers
		seed_cfg = 64'd1;
		squared_cfg = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests under the reset seed settings
		// draws starting from the unseeded zero state, narrow full span then wide full span
		push_request(1'b0, 1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 64'd1);
		push_request(1'b0, 1'b1, 64'd0, {64{1'b1}}, 64'd0);
		// reseed with the reset seed, then a reseed whose other fields are all ones
		push_request(1'b1, 1'b0, 64'd0, 64'd0, 64'd0);
		push_request(1'b1, 1'b1, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
		// single-value ranges at both ends
		push_request(1'b0, 1'b1, {64{1'b1}}, {64{1'b1}}, 64'd1);
		push_request(1'b0, 1'b0, 64'd0, 64'd0, 64'd0);
		push_request(1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
		// inverted bounds in both widths
		push_request(1'b0, 1'b1, 64'd100, 64'd5, 64'd1);
		push_request(1'b0, 1'b0, 64'd100, 64'd5, 64'd1);
		// narrow mode ignores the upper halves; step here is zero in its low half
		push_request(1'b0, 1'b0, 64'hFFFF_FFFF_0000_0010, 64'hAAAA_AAAA_0000_0100,
			64'h1234_5678_0000_0000);
		// step larger than the span, and the largest step of all
		push_request(1'b0, 1'b0, 64'd0, 64'd9, 64'd1000);
		push_request(1'b0, 1'b1, 64'd0, 64'd1_000_000, {64{1'b1}});
		// signed full range wraps to a zero span
		push_request(1'b0, 1'b1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
		push_request(1'b0, 1'b0, 64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF, 64'd0);
		// signed ranges across zero with a step, narrow then wide
		push_request(1'b0, 1'b0, 64'h0000_0000_FFFF_FF00, 64'h0000_0000_0000_0100, 64'd7);
		push_request(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FC18, 64'd1000, 64'd7);
		// wide small span with a zero step, narrow largest step
		push_request(1'b0, 1'b1, 64'd50, 64'd60, 64'd0);
		push_request(1'b0, 1'b0, 64'd0, 64'h0000_0000_FFFF_FFFE, 64'h0000_0000_FFFF_FFFF);

		// seed phases: zero and all-ones seeds raw and squared, then random settings
		run_phase(64'd0, 1'b0, '0);
		run_phase({64{1'b1}}, 1'b1, '0);
		run_phase({64{1'b1}}, 1'b0, {64{1'b1}});
		run_phase(64'd0, 1'b1, '0);
		repeat (3)
			run_phase(rand64(), 1'($urandom_range(0, 1)), rand64());

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predicted_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
		if (n_errors == 0)
			$display("splitmix64_ranged_random test passed");
		else
			$display("splitmix64_ranged_random test failed");
		$finish;
	end

endmodule

`default_nettype wire
